@@ design/vibc_pkg.sv @@
// ----------------------------------------------------------------------------
// vibc_pkg: shared definitions for the vertex index batch cache
// Default sizes, field widths, register addresses and the configuration
// register reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package vibc_pkg;

	// Default geometry of the batch table.
	localparam int unsigned DefCacheDepth = 64;
	localparam int unsigned DefIndexWidth = 32;

	// Fixed widths of the transaction fields.
	localparam int unsigned VertexW = 32;
	localparam int unsigned SlotW   = 6;
	localparam int unsigned ThreshW = 6;

	// Configuration port.
	localparam int unsigned ApbAddrW = 3;
	localparam int unsigned ApbDataW = 32;

	// Register word indexes (byte address is four times the index).
	localparam logic [ApbAddrW-3:0] RegEmitThreshold = 1'b0;

	localparam logic [ThreshW-1:0] EmitThresholdReset = 6'd48;

	// Position of the closing vertex within a triangle.
	localparam logic [1:0] TriLastPos = 2'd2;

endpackage : vibc_pkg

`default_nettype wire

@@ design/vibc_regs.sv @@
// ----------------------------------------------------------------------------
// vibc_regs: configuration register file
// Holds the emit threshold behind an APB-style port that never waits.
// ----------------------------------------------------------------------------
`default_nettype none

module vibc_regs
	import vibc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ApbAddrW-1:0] paddr,
	input  wire logic [ApbDataW-1:0] pwdata,
	output logic      [ApbDataW-1:0] prdata,
	output logic                     pready,
	output logic      [ThreshW-1:0]  emit_threshold
);

	logic [ThreshW-1:0] emit_threshold_q;
	logic               wr_en;
	logic               sel_thresh;

	// Only the word index matters; the byte offset bits are ignored.
	assign sel_thresh = (paddr[ApbAddrW-1:2] == RegEmitThreshold);
	assign wr_en      = psel && penable && pwrite && sel_thresh;
	assign pready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_threshold_q <= EmitThresholdReset;
		end else if (wr_en) begin
			emit_threshold_q <= pwdata[ThreshW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_thresh) begin
			prdata[ThreshW-1:0] = emit_threshold_q;
		end
	end

	assign emit_threshold = emit_threshold_q;

endmodule : vibc_regs

`default_nettype wire

@@ design/vibc_cam.sv @@
// ----------------------------------------------------------------------------
// vibc_cam: batch index table with associative lookup
// Compares a key against every filled entry in parallel and appends on miss.
// ----------------------------------------------------------------------------
`default_nettype none

module vibc_cam
	import vibc_pkg::*;
#(
	parameter int unsigned CACHE_DEPTH = DefCacheDepth,
	parameter int unsigned INDEX_WIDTH = DefIndexWidth,
	localparam int unsigned AW = $clog2(CACHE_DEPTH),
	localparam int unsigned CW = $clog2(CACHE_DEPTH + 1)
) (
	input  wire logic                   clk,
	input  wire logic [INDEX_WIDTH-1:0] key,
	input  wire logic [CW-1:0]          fill_count,
	input  wire logic                   wr_en,
	input  wire logic [AW-1:0]          wr_addr,
	output logic                        match_hit,
	output logic      [AW-1:0]          match_slot
);

	logic [INDEX_WIDTH-1:0] table_q [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= key;
		end
	end

	// Entries at or above the fill count belong to no batch and never match.
	for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cmp
		assign match[k] = (CW'(k) < fill_count) && (table_q[k] == key);
	end

	// Filled entries are distinct, so at most one bit is set and an OR
	// encoder gives its position.
	always_comb begin
		match_slot = '0;
		for (int unsigned k = 0; k < CACHE_DEPTH; k++) begin
			if (match[k]) begin
				match_slot = match_slot | AW'(k);
			end
		end
	end

	assign match_hit = |match;

endmodule : vibc_cam

`default_nettype wire

@@ design/vertex_index_batch_cache.sv @@
// ----------------------------------------------------------------------------
// vertex_index_batch_cache: batch-local vertex index de-duplication
// Looks up each vertex index of a triangle-list stream in the current batch
// and assigns it a slot, requesting a fetch on first use.
// ----------------------------------------------------------------------------
// The block accepts one index transaction per clock cycle while in_stall is
// low and returns one result transaction for each. The index is first held
// in the input register; then the table lookup, the append and the
// batch-close decision are made in a single pass and land in the result
// register. The throughput is set by that single pass, a parallel compare
// of the incoming index against every filled table entry.
// On a hit the stored slot is returned; on a miss the index is appended at
// the next free slot, returned in fetch_index and hit is low. batch_end is
// high when the batch closes after this index: at a triangle end with at
// least emit_threshold distinct entries, at the last index of a draw, or
// when the table becomes full. The table is then empty for the next index.
`default_nettype none

module vertex_index_batch_cache
	import vibc_pkg::*;
#(
	parameter int unsigned CACHE_DEPTH = DefCacheDepth,
	parameter int unsigned INDEX_WIDTH = DefIndexWidth
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration port.
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ApbAddrW-1:0] paddr,
	input  wire logic [ApbDataW-1:0] pwdata,
	output logic      [ApbDataW-1:0] prdata,
	output logic                     pready,
	// Index input channel.
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [VertexW-1:0]  vertex_index,
	input  wire logic                last_of_draw,
	// Result output channel.
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [SlotW-1:0]    slot,
	output logic                     hit,
	output logic      [VertexW-1:0]  fetch_index,
	output logic                     batch_end
);

	localparam int unsigned AW   = $clog2(CACHE_DEPTH);
	localparam int unsigned CW   = $clog2(CACHE_DEPTH + 1);
	localparam int unsigned CMPW = (CW > ThreshW) ? CW : ThreshW;

	// Configuration.
	logic [ThreshW-1:0] emit_threshold;

	vibc_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.emit_threshold (emit_threshold)
	);

	// Input register stage.
	logic                   valid_s1;
	logic [INDEX_WIDTH-1:0] index_s1;
	logic                   last_s1;
	logic                   advance;

	// The input register moves on whenever the result register is free or
	// is being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			index_s1 <= vertex_index[INDEX_WIDTH-1:0];
			last_s1  <= last_of_draw;
		end
	end

	// Batch state.
	logic [CW-1:0] entry_count_q;
	logic [1:0]    tri_pos_q;

	// Lookup.
	logic          match_hit;
	logic [AW-1:0] match_slot;
	logic [AW-1:0] append_slot;
	logic [CW-1:0] append_count;
	logic [CW-1:0] count_after;
	logic          table_full;
	logic          close;
	logic [AW-1:0] result_slot;

	// A count that has reached the depth wraps the append back to slot zero.
	assign append_slot = (entry_count_q >= CW'(CACHE_DEPTH)) ? '0
	                     : entry_count_q[AW-1:0];
	assign append_count = CW'(append_slot) + CW'(1);

	vibc_cam #(
		.CACHE_DEPTH (CACHE_DEPTH),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_cam (
		.clk        (clk),
		.key        (index_s1),
		.fill_count (entry_count_q),
		.wr_en      (advance && !match_hit),
		.wr_addr    (append_slot),
		.match_hit  (match_hit),
		.match_slot (match_slot)
	);

	assign count_after = match_hit ? entry_count_q : append_count;
	assign table_full  = !match_hit && (append_count >= CW'(CACHE_DEPTH));
	assign result_slot = match_hit ? match_slot : append_slot;

	// The threshold test uses the count after any append of this index.
	assign close = ((tri_pos_q == TriLastPos)
	                && (CMPW'(count_after) >= CMPW'(emit_threshold)))
	               || last_s1 || table_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			tri_pos_q     <= '0;
		end else if (advance) begin
			entry_count_q <= close ? '0 : count_after;
			if (last_s1 || tri_pos_q >= TriLastPos) begin
				tri_pos_q <= '0;
			end else begin
				tri_pos_q <= tri_pos_q + 2'd1;
			end
		end
	end

	// Result register.
	logic                           out_valid_q;
	logic [SlotW-1:0]               slot_q;
	logic                           hit_q;
	logic [VertexW-1:0]             fetch_index_q;
	logic                           batch_end_q;
	logic [AW+SlotW-1:0]            slot_wide;
	logic [INDEX_WIDTH+VertexW-1:0] fetch_wide;

	// Slots beyond the field width keep only their low bits.
	assign slot_wide  = {{SlotW{1'b0}}, result_slot};
	assign fetch_wide = {{VertexW{1'b0}}, index_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_q        <= slot_wide[SlotW-1:0];
			hit_q         <= match_hit;
			fetch_index_q <= match_hit ? '0 : fetch_wide[VertexW-1:0];
			batch_end_q   <= close;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot        = slot_q;
	assign hit         = hit_q;
	assign fetch_index = fetch_index_q;
	assign batch_end   = batch_end_q;

endmodule : vertex_index_batch_cache

`default_nettype wire

@@ bench/vibc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vibc_checker: slot predictor and result scoreboard for the batch cache
// Follows register writes and accepted index transactions, works out the slot,
// hit, fetch index and batch close of each one, and compares the result
// transactions against those predictions in order.
// ----------------------------------------------------------------------------
module vibc_checker
	import vibc_pkg::*;
#(
	parameter int unsigned CACHE_DEPTH = DefCacheDepth,
	parameter int unsigned INDEX_WIDTH = DefIndexWidth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	input  logic                pready,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [VertexW-1:0]  vertex_index,
	input  logic                last_of_draw,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [SlotW-1:0]    slot,
	input  logic                hit,
	input  logic [VertexW-1:0]  fetch_index,
	input  logic                batch_end,
	output int                  errors,
	output int                  pending,
	output int                  results_seen,
	output int                  hits_seen,
	output int                  batches_seen,
	output int                  full_closes
);

	typedef struct packed {
		logic [SlotW-1:0]   slot;
		logic               hit;
		logic [VertexW-1:0] fetch_index;
		logic               batch_end;
	} slot_result_t;

	localparam logic [VertexW-1:0] IndexMask = VertexW'((64'd1 << INDEX_WIDTH) - 64'd1);

	logic [VertexW-1:0] batch_index [CACHE_DEPTH];
	int unsigned        batch_fill;
	logic [1:0]         tri_pos;
	logic [ThreshW-1:0] threshold;
	slot_result_t       slot_expect_q [$];
	int mismatch_count, result_count, hit_count, close_count, fill_close_count;

	// Looks the index up among the filled entries of the batch, appends it on a
	// miss and decides whether the batch closes after it.
	function automatic slot_result_t lookup_and_append(input logic [VertexW-1:0] raw_index,
			input logic draw_end);
		logic [VertexW-1:0] key;
		int unsigned        pos;
		bit                 found, table_full, closes;
		slot_result_t       r;
		key = raw_index & IndexMask;
		found = 1'b0;
		table_full = 1'b0;
		pos = 0;
		for (int unsigned k = 0; k < batch_fill; k++) begin
			if (!found && batch_index[k] == key) begin
				found = 1'b1;
				pos = k;
			end
		end
		if (!found) begin
			if (batch_fill >= CACHE_DEPTH)
				batch_fill = 0;
			pos = batch_fill;
			batch_index[pos] = key;
			batch_fill++;
			table_full = (batch_fill >= CACHE_DEPTH);
		end
		closes = (tri_pos == TriLastPos && batch_fill >= threshold) || draw_end || table_full;
		r.slot = pos[SlotW-1:0];
		r.hit = found;
		r.fetch_index = found ? '0 : key;
		r.batch_end = closes;
		if (table_full)
			fill_close_count++;
		if (closes)
			batch_fill = 0;
		if (draw_end || tri_pos >= TriLastPos)
			tri_pos = '0;
		else
			tri_pos = tri_pos + 2'd1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_result_t got, want, predicted;
		bit           bad;
		if (!arst_n) begin
			batch_fill = 0;
			tri_pos = '0;
			threshold = EmitThresholdReset;
			slot_expect_q.delete();
			mismatch_count = 0;
			result_count = 0;
			hit_count = 0;
			close_count = 0;
			fill_close_count = 0;
		end else begin
			// Results are checked before new predictions are queued.
			if (out_valid && !out_stall) begin
				got = {slot, hit, fetch_index, batch_end};
				result_count++;
				if (got.hit === 1'b1)
					hit_count++;
				if (got.batch_end === 1'b1)
					close_count++;
				if (slot_expect_q.size() == 0) begin
					$error("result transaction with no prediction waiting: slot %0d", got.slot);
					mismatch_count++;
				end else begin
					want = slot_expect_q.pop_front();
					bad = 1'b0;
					if (got.slot !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, got.slot);
						bad = 1'b1;
					end
					if (got.hit !== want.hit) begin
						$error("hit: expected %0b, actual %0b", want.hit, got.hit);
						bad = 1'b1;
					end
					if (got.fetch_index !== want.fetch_index) begin
						$error("fetch_index: expected 0x%08h, actual 0x%08h",
							want.fetch_index, got.fetch_index);
						bad = 1'b1;
					end
					if (got.batch_end !== want.batch_end) begin
						$error("batch_end: expected %0b, actual %0b", want.batch_end, got.batch_end);
						bad = 1'b1;
					end
					if (bad)
						mismatch_count++;
				end
			end
			if (psel && penable && pwrite && pready && paddr[ApbAddrW-1:2] == RegEmitThreshold)
				threshold = pwdata[ThreshW-1:0];
			if (in_valid && !in_stall) begin
				predicted = lookup_and_append(vertex_index, last_of_draw);
				slot_expect_q.insert(slot_expect_q.size(), predicted);
			end
		end
		errors <= mismatch_count;
		pending <= slot_expect_q.size();
		results_seen <= result_count;
		hits_seen <= hit_count;
		batches_seen <= close_count;
		full_closes <= fill_close_count;
	end

endmodule

@@ bench/tb_vertex_index_batch_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_index_batch_cache: regression bench for the vertex index batch cache
// Drives index transactions and threshold writes into the block, lets the
// checker predict and compare every result, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_vertex_index_batch_cache;
	import vibc_pkg::*;

	localparam int ClkHalf     = 4;
	localparam int ResetCycles = 6;
	// The block returns one result per cycle when nothing stalls. Even with
	// every item behind the longest sender gap and a mostly stalled receiver,
	// about 400 transactions finish far below this count.
	localparam int CycleLimit  = 200000;
	// Length of the one long receiver hold-off; well beyond the block's depth.
	localparam int HoldCycles  = 200;
	// Settling time after the last result before a register write or the end.
	localparam int DrainCycles = 8;
	localparam int PhaseItems  = 35;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ApbAddrW-1:0] paddr = '0;
	logic [ApbDataW-1:0] pwdata = '0;
	logic [ApbDataW-1:0] prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [VertexW-1:0]  vertex_index = '0;
	logic                last_of_draw = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [SlotW-1:0]    slot;
	logic                hit;
	logic [VertexW-1:0]  fetch_index;
	logic                batch_end;

	int errors, pending, results_seen, hits_seen, batches_seen, full_closes;
	int cycle_count = 0;
	int items_sent = 0;
	int burst_left = 0;

	always begin
		#(ClkHalf) clk = 1'b1;
		#(ClkHalf) clk = 1'b0;
	end

	vertex_index_batch_cache u_top (.*);

	// The checker sits beside the block and sees the same wires.
	vibc_checker u_check (.*);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one index transaction and returns at the edge where it is taken.
	// The sender works in bursts; between bursts valid drops for a random gap,
	// and about a quarter of the bursts follow the previous one back to back.
	task automatic present_vertex(input logic [VertexW-1:0] v, input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		vertex_index <= v;
		last_of_draw <= l;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Stops offering and waits until every predicted result has come back,
	// then lets the pipeline settle. The block is idle afterwards.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Two-phase register write: setup, then access until pready.
	task automatic write_threshold(input logic [ThreshW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {RegEmitThreshold, 2'b00};
		pwdata <= ApbDataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One random phase at a fixed threshold. Most of the traffic is
	// well-formed triangle-list draws that reuse a small pool of indices, so
	// hits are frequent and batches close on triangle ends. The rest is draws
	// cut short, long runs with no draw end that build up large batches, and
	// plain noise with random draw ends. Every phase finishes with a draw end
	// so that the next one starts at the first vertex of a triangle.
	task automatic random_phase(input logic [ThreshW-1:0] thr, input int quota);
		logic [VertexW-1:0] pool [40];
		logic [VertexW-1:0] base;
		int start, kind, len, pool_n;
		wait_idle();
		write_threshold(thr);
		start = items_sent;
		if (thr == '1) begin
			// Table-full close: a repeat in the first triangle shifts the
			// batch count against the triangle position, so the 63rd entry
			// lands mid-triangle and the 64th append fills the table.
			base = $urandom();
			present_vertex(base - 1, 1'b0);
			present_vertex(base - 1, 1'b0);
			for (int k = 2; k < 70; k++)
				present_vertex(base + k, 1'b0);
			present_vertex(base, 1'b1);
		end
		while (items_sent - start < quota) begin
			kind = $urandom_range(0, 9);
			pool_n = (kind >= 8) ? $urandom_range(8, 40) : $urandom_range(1, 12);
			for (int k = 0; k < pool_n; k++)
				pool[k] = ($urandom_range(0, 7) == 0) ? VertexW'($urandom_range(0, 3)) : $urandom();
			if (kind == 7) begin
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++)
					present_vertex($urandom(), $urandom_range(0, 7) == 0);
			end else begin
				len = (kind <= 5) ? 3 * $urandom_range(1, 8) :
				      (kind == 6) ? $urandom_range(1, 10) : $urandom_range(20, 70);
				for (int k = 0; k < len; k++)
					present_vertex(pool[$urandom_range(0, pool_n - 1)],
						kind <= 6 && k == len - 1);
			end
		end
		present_vertex($urandom(), 1'b1);
	endtask

	// Receiver: keeps each stall pattern (never, sparse, dense or periodic) for
	// a random span. Once enough results have passed it holds the output off
	// for a long stretch while the sender keeps offering, so the block fills
	// and has to stall its input.
	initial begin
		int  mode, span;
		bit  held;
		held = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 120);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((cycle_count % 5) < 2);
				endcase
			end
			if (!held && results_seen >= 120) begin
				held = 1'b1;
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [VertexW-1:0] zero_thr_seq [6];
		zero_thr_seq = '{32'h0000_000A, 32'h0000_000B, 32'h0000_000A,
		                 32'h0000_000A, 32'h0000_000C, 32'h0000_000D};

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold. The index extremes go in
		// first; the second and third triangles repeat earlier indices.
		present_vertex(32'h0000_0000, 1'b0);
		present_vertex(32'hFFFF_FFFF, 1'b0);
		present_vertex(32'h0000_0000, 1'b0);
		present_vertex(32'h8000_0000, 1'b0);
		present_vertex(32'h7FFF_FFFF, 1'b0);
		present_vertex(32'hFFFF_FFFF, 1'b0);
		// A triangle of one repeated index that ends the draw.
		present_vertex(32'h0000_0001, 1'b0);
		present_vertex(32'h0000_0001, 1'b0);
		present_vertex(32'h0000_0001, 1'b1);
		// A draw that ends mid-triangle, then a draw of a single index.
		present_vertex(32'h0000_0005, 1'b0);
		present_vertex(32'h0000_0006, 1'b1);
		present_vertex(32'h0000_0007, 1'b1);

		// Threshold zero: every triangle end closes the batch.
		wait_idle();
		write_threshold('0);
		foreach (zero_thr_seq[k])
			present_vertex(zero_thr_seq[k], k == 5);

		// Random part over several thresholds, extremes included. The
		// all-ones threshold phase also drives the table to full.
		random_phase(ThreshW'(1), PhaseItems);
		random_phase(ThreshW'(62), PhaseItems);
		random_phase('1, PhaseItems);
		random_phase(ThreshW'($urandom_range(2, 61)), PhaseItems);
		random_phase('0, PhaseItems);
		random_phase(ThreshW'($urandom_range(2, 61)), PhaseItems);
		random_phase(EmitThresholdReset, PhaseItems);

		wait_idle();

		$display("Sent %0d index transactions; checked %0d results, %0d hits, %0d batch closes.",
			items_sent, results_seen, hits_seen, batches_seen);
		$display("Thresholds 0, 1, 62, 63 and random ones; %0d full-table closes; one %0d-cycle hold.",
			full_closes, HoldCycles);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d result transactions failed.", errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
